FILE: rtl/core/ubxfp_pkg.sv
// Shared types, codes and helpers for the binary frame parser.
// No dependencies; imported by every file of the block but ubxfp_ifs.
package ubxfp_pkg;

  // Sync pair and header limits
  localparam logic [7:0]  SYNC_FIRST     = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND    = 8'h62;
  localparam logic [15:0] MAX_LEN_RESET  = 16'd127;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BADSUM  = 2'd2;
  localparam logic [1:0] KIND_TOOLONG = 2'd3;

  // Message types
  localparam logic [2:0] MT_OTHER   = 3'd0;
  localparam logic [2:0] MT_ACK     = 3'd1;
  localparam logic [2:0] MT_NAK     = 3'd2;
  localparam logic [2:0] MT_NAV_PVT = 3'd3;
  localparam logic [2:0] MT_CFG_NAV5 = 3'd4;

  // Class and id codes of the recognized messages
  localparam logic [7:0] CLS_NAV = 8'h01;
  localparam logic [7:0] CLS_ACK = 8'h05;
  localparam logic [7:0] CLS_CFG = 8'h06;
  localparam logic [7:0] ID_ACK  = 8'h01;
  localparam logic [7:0] ID_NAK  = 8'h00;
  localparam logic [7:0] ID_PVT  = 8'h07;
  localparam logic [7:0] ID_NAV5 = 8'h24;

  // One result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  frm_class;
    logic [7:0]  msg_id;
    logic [2:0]  msg_type;
    logic [7:0]  pl_byte;
    logic [15:0] pl_offset;
    logic [15:0] frame_len;
  } result_t;

  // Handshake control between the stages
  typedef struct packed {
    logic advance;   // word in the input register is consumed this cycle
    logic load;      // a result is written into the output register
  } stage_ctl_t;

  function automatic logic [2:0] classify(input logic [7:0] c, input logic [7:0] i);
    logic [2:0] t;
    t = MT_OTHER;
    priority if (c == CLS_ACK && i == ID_ACK) t = MT_ACK;
    else if (c == CLS_ACK && i == ID_NAK)     t = MT_NAK;
    else if (c == CLS_NAV && i == ID_PVT)     t = MT_NAV_PVT;
    else if (c == CLS_CFG && i == ID_NAV5)    t = MT_CFG_NAV5;
    else                                      t = MT_OTHER;
    return t;
  endfunction

endpackage

FILE: rtl/core/ubxfp_ifs.sv
// Valid/ready channel interfaces of the frame parser: byte in, result out, config.
// Depends on nothing but plain logic types.
interface ubxfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ubxfp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  message_class;
  logic [7:0]  message_id;
  logic [2:0]  message_type;
  logic [7:0]  payload_byte;
  logic [15:0] payload_offset;
  logic [15:0] frame_length;
  modport source (output valid, output result_kind, output message_class,
                  output message_id, output message_type, output payload_byte,
                  output payload_offset, output frame_length, input ready);
  modport sink   (input valid, input result_kind, input message_class,
                  input message_id, input message_type, input payload_byte,
                  input payload_offset, input frame_length, output ready);
endinterface

interface ubxfp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/ubxfp_in_reg.sv
// Input register of the frame parser: holds one received byte until parsed.
// Depends on ubxfp_pkg and ubxfp_byte_if.
module ubxfp_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  ubxfp_byte_if.sink          in_if,
  input  logic                out_free,
  output logic                byte_valid,
  output logic [7:0]          byte_data,
  output ubxfp_pkg::stage_ctl_t ctl
);
  import ubxfp_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       advance;

  // Consume the held byte when the output side has room
  assign advance      = valid_r && out_free;
  assign in_if.ready  = !valid_r || advance;
  assign byte_valid   = valid_r;
  assign byte_data    = data_r;
  assign ctl.advance  = advance;
  assign ctl.load     = 1'b0;

  always_comb begin
    valid_nxt = valid_r;
    if (in_if.valid && in_if.ready) valid_nxt = 1'b1;
    else if (advance)               valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) data_r <= in_if.rx_byte;
  end

endmodule

FILE: rtl/core/ubxfp_parse.sv
// Frame state machine with Fletcher-8 sum; one byte per advance.
// Depends on ubxfp_pkg.
module ubxfp_parse (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ubxfp_pkg::stage_ctl_t  ctl_in,
  input  logic [7:0]             rx_b,
  input  logic [15:0]            max_len,
  output logic                   res_valid,
  output ubxfp_pkg::result_t     res
);
  import ubxfp_pkg::*;

  typedef enum logic [8:0] {
    PH_HUNT    = 9'b000000001,
    PH_SYNC    = 9'b000000010,
    PH_CLASS   = 9'b000000100,
    PH_ID      = 9'b000001000,
    PH_LEN_LO  = 9'b000010000,
    PH_LEN_HI  = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_CHECK_A = 9'b010000000,
    PH_CHECK_B = 9'b100000000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  chk_a_r, chk_a_nxt;
  logic [7:0]  add_a, add_b;
  logic [15:0] len_full;
  logic [15:0] left_dec;

  // Running Fletcher sum with this byte folded in
  assign add_a    = sum_a_r + rx_b;
  assign add_b    = sum_b_r + add_a;
  assign len_full = {rx_b, len_r[7:0]};
  assign left_dec = left_r - 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    class_nxt = class_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    chk_a_nxt = chk_a_r;
    res_valid = 1'b0;
    res.kind      = KIND_PAYLOAD;
    res.pl_byte   = 8'd0;
    res.pl_offset = 16'd0;
    unique case (phase_r)
      PH_HUNT: begin
        if (rx_b == SYNC_FIRST) phase_nxt = PH_SYNC;
      end
      PH_SYNC: begin
        phase_nxt = (rx_b == SYNC_SECOND) ? PH_CLASS : PH_HUNT;
      end
      PH_CLASS: begin
        sum_a_nxt = rx_b;
        sum_b_nxt = rx_b;
        class_nxt = rx_b;
        phase_nxt = PH_ID;
      end
      PH_ID: begin
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        id_nxt    = rx_b;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        len_nxt   = {8'd0, rx_b};
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        len_nxt   = len_full;
        if (len_full > max_len) begin
          // oversize frame: report and resync
          res_valid = 1'b1;
          res.kind  = KIND_TOOLONG;
          phase_nxt = PH_HUNT;
        end else begin
          left_nxt  = len_full;
          phase_nxt = (len_full == 16'd0) ? PH_CHECK_A : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_a_nxt     = add_a;
        sum_b_nxt     = add_b;
        res_valid     = 1'b1;
        res.kind      = KIND_PAYLOAD;
        res.pl_byte   = rx_b;
        res.pl_offset = len_r - left_r;
        left_nxt      = left_dec;
        if (left_dec == 16'd0) phase_nxt = PH_CHECK_A;
      end
      PH_CHECK_A: begin
        chk_a_nxt = rx_b;
        phase_nxt = PH_CHECK_B;
      end
      PH_CHECK_B: begin
        res_valid = 1'b1;
        res.kind  = (chk_a_r == sum_a_r && rx_b == sum_b_r) ? KIND_GOOD : KIND_BADSUM;
        phase_nxt = PH_HUNT;
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
    // Header fields reflect what this byte leaves behind
    res.frm_class = class_nxt;
    res.msg_id    = id_nxt;
    res.msg_type  = classify(class_nxt, id_nxt);
    res.frame_len = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
    end else if (ctl_in.advance) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.advance) begin
      class_r <= class_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      chk_a_r <= chk_a_nxt;
    end
  end

  // Checks
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(phase_r))
    else $error("parse phase not one-hot");

  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> left_r != 16'd0)
    else $error("payload phase with no bytes left");

  a_payload_kind: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.kind == KIND_PAYLOAD |-> phase_r == PH_PAYLOAD)
    else $error("payload word outside payload phase");

  a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_in.advance && phase_r == PH_CHECK_B |=> phase_r == PH_HUNT)
    else $error("no resync after check bytes");

endmodule

FILE: rtl/core/ubxfp_out_reg.sv
// Output register of the frame parser: holds one result word until taken.
// Depends on ubxfp_pkg and ubxfp_result_if.
module ubxfp_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ubxfp_pkg::stage_ctl_t ctl,
  input  ubxfp_pkg::result_t    res,
  output logic                  out_free,
  ubxfp_result_if.source        out_if
);
  import ubxfp_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;

  // Room when empty or when the held word leaves this cycle
  assign out_free = !valid_r || out_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.load)          valid_nxt = 1'b1;
    else if (out_if.ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) data_r <= res;
  end

  assign out_if.valid          = valid_r;
  assign out_if.result_kind    = data_r.kind;
  assign out_if.message_class  = data_r.frm_class;
  assign out_if.message_id     = data_r.msg_id;
  assign out_if.message_type   = data_r.msg_type;
  assign out_if.payload_byte   = data_r.pl_byte;
  assign out_if.payload_offset = data_r.pl_offset;
  assign out_if.frame_length   = data_r.frame_len;

endmodule

FILE: rtl/core/ubxfp_frame_parser_core.sv
// Top level of the binary frame parser: input register, parser, output register.
// Depends on ubxfp_pkg, ubxfp_ifs, ubxfp_in_reg, ubxfp_parse and ubxfp_out_reg.
//
// Takes one received byte per cycle and gives at most one result word per byte:
// each payload byte with its offset, then a good or bad checksum status with the
// second check byte, or a too-long status right after the length field when the
// length exceeds the configured maximum (reset 127). The parser stage sits between
// the input register and the output register and forms its result combinationally,
// so a byte's result is written into the output register as the byte is consumed,
// and the block sustains one byte per cycle while the result side is ready. Write
// the maximum payload length only while no byte is in flight.
module ubx_frame_parser_core (
  input  logic           clk,
  input  logic           rst_n,
  ubxfp_byte_if.sink     in_if,
  ubxfp_result_if.source out_if,
  ubxfp_cfg_if.sink      cfg_if
);
  import ubxfp_pkg::*;

  logic        out_free;
  logic        byte_valid;
  logic [7:0]  byte_data;
  logic        res_valid;
  result_t     res;
  stage_ctl_t  in_ctl;
  stage_ctl_t  out_ctl;
  logic [15:0] max_len_r;

  // Maximum payload length register
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_if.valid) begin
      max_len_r <= cfg_if.data;
    end
  end

  ubxfp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .out_free   (out_free),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .ctl        (in_ctl)
  );

  ubxfp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (in_ctl),
    .rx_b      (byte_data),
    .max_len   (max_len_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result is loaded only when the parser actually consumes a byte
  assign out_ctl.advance = in_ctl.advance;
  assign out_ctl.load    = in_ctl.advance && byte_valid && res_valid;

  ubxfp_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (out_ctl),
    .res      (res),
    .out_free (out_free),
    .out_if   (out_if)
  );

endmodule
